@@ hw/rtl/tcpft_pkg.sv @@
`default_nettype none

package tcpft_pkg;

  localparam int unsigned MAX_FLOWS = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned CFG_W     = 16;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOT_TCP  = 3'd3;
  localparam logic [2:0] ST_READ_OK  = 3'd4;
  localparam logic [2:0] ST_READ_BAD = 3'd5;

  localparam logic [1:0] CLASS_HTTP  = 2'd0;
  localparam logic [1:0] CLASS_HTTPS = 2'd1;
  localparam logic [1:0] CLASS_OTHER = 2'd2;

  localparam logic       CMD_PACKET = 1'b0;
  localparam logic       CMD_READ   = 1'b1;

  localparam logic [7:0] PROTO_TCP = 8'd6;

  localparam logic       REG_HTTP_PORT  = 1'b0;
  localparam logic       REG_HTTPS_PORT = 1'b1;

  localparam logic [15:0] HTTP_PORT_RST  = 16'd80;
  localparam logic [15:0] HTTPS_PORT_RST = 16'd443;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             command;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [15:0]      src_tcp_port;
    logic [15:0]      dst_port;
    logic [7:0]       ip_protocol;
    logic [IDX_W-1:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] flow_index;
    logic [31:0]      pkt_count;
    logic [1:0]       traffic_class;
    logic [31:0]      entry_src_addr;
    logic [31:0]      entry_dst_addr;
    logic [15:0]      entry_src_tcp_port;
    logic [15:0]      entry_dst_port;
    logic [CNT_W-1:0] flows_in_use;
  } out_item_t;

  // request walking down the cell row
  typedef struct packed {
    logic             valid;
    logic             command;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [15:0]      src_tcp_port;
    logic [15:0]      dst_port;
    logic [IDX_W-1:0] entry_index;
    logic [1:0]       cls;
    logic [CNT_W-1:0] used;
    logic             done;
    out_item_t        res;
  } token_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcp_flow_table_counter_core.sv @@
`default_nettype none

// TCP flow counter over a row of MAX_FLOWS flow cells. Each transfer on the input is
// either a packet header (command 0) or a read of one stored entry (command 1), and
// gives exactly one result. A request enters a token register and then walks the cell
// row one cell per clock; each cell compares against its own entry, counts a hit,
// claims itself for a new flow if it is the first free cell, or returns its entry on a
// read. One item is in flight at a time: the result is registered after the token has
// passed the token register and every cell, and the next input is taken in the cycle
// the result transfers, so a new item cannot enter before the last result has left.
// The user is to write the port registers through cfg_write only while idle; the block
// itself does not enforce it. No clearing pass is needed after reset.
module tcp_flow_table_counter_core
  import tcpft_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output out_item_t        out_data,
  input  wire              cfg_write,
  input  wire              cfg_index,
  input  wire [CFG_W-1:0]  cfg_data
);

  logic [15:0]      http_port;
  logic [15:0]      https_port;
  logic [CNT_W-1:0] flows_used;
  logic [CNT_W-1:0] flows_used_next;
  logic             busy;
  logic             in_xfer;
  logic             out_xfer;
  logic [1:0]       cls_in;
  token_t           tok_start;
  token_t           tok [MAX_FLOWS+1];
  out_item_t        res_final;

  assign out_xfer = out_valid && !out_stall;
  assign in_stall = busy && !out_xfer;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      http_port  <= HTTP_PORT_RST;
      https_port <= HTTPS_PORT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HTTP_PORT:  http_port  <= cfg_data;
        REG_HTTPS_PORT: https_port <= cfg_data;
        default:        http_port  <= http_port;
      endcase
    end
  end

  always_comb begin
    priority if (in_data.dst_port == http_port) begin
      cls_in = CLASS_HTTP;
    end else if (in_data.dst_port == https_port) begin
      cls_in = CLASS_HTTPS;
    end else begin
      cls_in = CLASS_OTHER;
    end
  end

  // preset result; cells overwrite it when they claim the request
  always_comb begin
    tok_start              = '0;
    tok_start.valid        = 1'b1;
    tok_start.command      = in_data.command;
    tok_start.src_addr     = in_data.src_addr;
    tok_start.dst_addr     = in_data.dst_addr;
    tok_start.src_tcp_port = in_data.src_tcp_port;
    tok_start.dst_port     = in_data.dst_port;
    tok_start.entry_index  = in_data.entry_index;
    tok_start.cls          = cls_in;
    tok_start.used         = flows_used;
    priority if (in_data.command == CMD_READ) begin
      tok_start.res.status     = ST_READ_BAD;
      tok_start.res.flow_index = in_data.entry_index;
    end else if (in_data.ip_protocol != PROTO_TCP) begin
      tok_start.res.status = ST_NOT_TCP;
      tok_start.done       = 1'b1;
    end else begin
      tok_start.res.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0] <= '0;
    end else if (in_xfer) begin
      tok[0] <= tok_start;
    end else begin
      tok[0] <= '0;
    end
  end

  for (genvar i = 0; i < MAX_FLOWS; i++) begin : g_cell
    tcpft_cell #(
      .CELL_ID(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  assign flows_used_next = (tok[MAX_FLOWS].res.status == ST_NEW) ?
                           tok[MAX_FLOWS].used + CNT_W'(1) : tok[MAX_FLOWS].used;

  always_comb begin
    res_final              = tok[MAX_FLOWS].res;
    res_final.flows_in_use = flows_used_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      flows_used <= '0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (out_xfer) begin
        busy <= 1'b0;
      end
      if (tok[MAX_FLOWS].valid) begin
        out_valid  <= 1'b1;
        flows_used <= flows_used_next;
      end else if (out_xfer) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[MAX_FLOWS].valid) begin
      out_data <= res_final;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tcpft_cell.sv @@
`default_nettype none

module tcpft_cell
  import tcpft_pkg::*;
#(
  parameter int unsigned CELL_ID = 0
) (
  input  wire    clk,
  input  wire    rst,
  input  token_t tok_in,
  output token_t tok_out
);

  localparam logic [IDX_W-1:0] ID     = IDX_W'(CELL_ID);
  localparam logic [CNT_W-1:0] ID_CNT = CNT_W'(CELL_ID);

  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_tcp_port;
  logic [15:0] dst_port;
  logic [1:0]  cls;
  logic [31:0] packets;
  logic [31:0] packets_next;

  logic   in_use;
  logic   key_match;
  logic   do_hit;
  logic   do_new;
  token_t tok_next;

  assign in_use    = ID_CNT < tok_in.used;
  assign key_match = in_use && (src_addr == tok_in.src_addr) && (dst_addr == tok_in.dst_addr)
                     && (src_tcp_port == tok_in.src_tcp_port) && (dst_port == tok_in.dst_port);
  assign packets_next = (packets == COUNT_MAX) ? packets : packets + 32'd1;

  always_comb begin
    tok_next = tok_in;
    do_hit   = 1'b0;
    do_new   = 1'b0;
    if (tok_in.valid && !tok_in.done) begin
      priority if (tok_in.command == CMD_READ) begin
        if (in_use && tok_in.entry_index == ID) begin
          tok_next.done                   = 1'b1;
          tok_next.res.status             = ST_READ_OK;
          tok_next.res.flow_index         = ID;
          tok_next.res.pkt_count          = packets;
          tok_next.res.traffic_class      = cls;
          tok_next.res.entry_src_addr     = src_addr;
          tok_next.res.entry_dst_addr     = dst_addr;
          tok_next.res.entry_src_tcp_port = src_tcp_port;
          tok_next.res.entry_dst_port     = dst_port;
        end
      end else if (key_match) begin
        do_hit                          = 1'b1;
        tok_next.done                   = 1'b1;
        tok_next.res.status             = ST_HIT;
        tok_next.res.flow_index         = ID;
        tok_next.res.pkt_count          = packets_next;
        tok_next.res.traffic_class      = cls;
        tok_next.res.entry_src_addr     = src_addr;
        tok_next.res.entry_dst_addr     = dst_addr;
        tok_next.res.entry_src_tcp_port = src_tcp_port;
        tok_next.res.entry_dst_port     = dst_port;
      end else if (ID_CNT == tok_in.used) begin
        // first free cell: no valid entry matched above
        do_new                          = 1'b1;
        tok_next.done                   = 1'b1;
        tok_next.res.status             = ST_NEW;
        tok_next.res.flow_index         = ID;
        tok_next.res.pkt_count          = 32'd1;
        tok_next.res.traffic_class      = tok_in.cls;
        tok_next.res.entry_src_addr     = tok_in.src_addr;
        tok_next.res.entry_dst_addr     = tok_in.dst_addr;
        tok_next.res.entry_src_tcp_port = tok_in.src_tcp_port;
        tok_next.res.entry_dst_port     = tok_in.dst_port;
      end else begin
        tok_next.done = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_hit) begin
      packets <= packets_next;
    end
    if (do_new) begin
      src_addr     <= tok_in.src_addr;
      dst_addr     <= tok_in.dst_addr;
      src_tcp_port <= tok_in.src_tcp_port;
      dst_port     <= tok_in.dst_port;
      cls          <= tok_in.cls;
      packets      <= 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out       <= '0;
    end else begin
      tok_out       <= tok_next;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_tcp_flow_table_counter_core.sv @@
`timescale 1ns / 100ps

module tb_tcp_flow_table_counter_core;
  import tcpft_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_tcp_port;
    logic [15:0] dst_port;
    logic [1:0]  cls;
    logic [31:0] packets;
  } flow_rec_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_write;
  logic            cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // flow table as the block should hold it
  flow_rec_t       flow_tab [MAX_FLOWS];
  int unsigned     flows_used;
  logic [15:0]     cur_http_port;
  logic [15:0]     cur_https_port;

  out_item_t       flow_reports [$];
  int unsigned     errors = 0;
  int unsigned     cycle_count = 0;
  int unsigned     burst_left;
  int unsigned     stall_run = 0;
  logic            stall_level = 1'b0;

  tcp_flow_table_counter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [1:0] port_class(logic [15:0] port);
    if (port == cur_http_port) return CLASS_HTTP;
    if (port == cur_https_port) return CLASS_HTTPS;
    return CLASS_OTHER;
  endfunction

  function automatic out_item_t update_flow_table(in_item_t it);
    out_item_t r;
    int        idx;
    int        i;
    r = '0;
    idx = -1;
    if (it.command == CMD_READ) begin
      r.status = ST_READ_BAD;
      r.flow_index = it.entry_index;
      if (it.entry_index < flows_used) begin
        r.status = ST_READ_OK;
        idx = int'(it.entry_index);
      end
    end else if (it.ip_protocol != PROTO_TCP) begin
      r.status = ST_NOT_TCP;
    end else begin
      for (i = 0; i < flows_used; i++) begin
        if (idx < 0 && flow_tab[i].src_addr == it.src_addr &&
            flow_tab[i].dst_addr == it.dst_addr &&
            flow_tab[i].src_tcp_port == it.src_tcp_port &&
            flow_tab[i].dst_port == it.dst_port) begin
          idx = i;
        end
      end
      if (idx >= 0) begin
        r.status = ST_HIT;
        if (flow_tab[idx].packets != COUNT_MAX) flow_tab[idx].packets++;
      end else if (flows_used < MAX_FLOWS) begin
        r.status = ST_NEW;
        idx = int'(flows_used);
        flow_tab[idx].src_addr = it.src_addr;
        flow_tab[idx].dst_addr = it.dst_addr;
        flow_tab[idx].src_tcp_port = it.src_tcp_port;
        flow_tab[idx].dst_port = it.dst_port;
        flow_tab[idx].cls = port_class(it.dst_port);
        flow_tab[idx].packets = 32'd1;
        flows_used++;
      end else begin
        r.status = ST_FULL;
      end
    end
    if (idx >= 0) begin
      r.flow_index = IDX_W'(idx);
      r.pkt_count = flow_tab[idx].packets;
      r.traffic_class = flow_tab[idx].cls;
      r.entry_src_addr = flow_tab[idx].src_addr;
      r.entry_dst_addr = flow_tab[idx].dst_addr;
      r.entry_src_tcp_port = flow_tab[idx].src_tcp_port;
      r.entry_dst_port = flow_tab[idx].dst_port;
    end
    r.flows_in_use = CNT_W'(flows_used);
    return r;
  endfunction

  function automatic in_item_t make_packet(logic [31:0] sa, logic [31:0] da,
                                           logic [15:0] sp, logic [15:0] dp,
                                           logic [7:0] proto);
    in_item_t p;
    p.command = CMD_PACKET;
    p.src_addr = sa;
    p.dst_addr = da;
    p.src_tcp_port = sp;
    p.dst_port = dp;
    p.ip_protocol = proto;
    p.entry_index = IDX_W'($urandom);
    return p;
  endfunction

  function automatic in_item_t make_read(logic [IDX_W-1:0] idx);
    in_item_t p;
    p = make_packet($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
    p.command = CMD_READ;
    p.entry_index = idx;
    return p;
  endfunction

  task automatic send_item(input in_item_t item);
    if (!in_valid) in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    flow_reports.push_back(update_flow_table(item));
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 20) : $urandom_range(8, 0);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (flow_reports.size() != 0) @(posedge clk);
    repeat (MAX_FLOWS + 4) @(posedge clk);
  endtask

  task automatic set_ports(input logic [15:0] http_val, input logic [15:0] https_val);
    cfg_write <= 1'b1;
    cfg_index <= REG_HTTP_PORT;
    cfg_data <= http_val;
    @(posedge clk);
    cfg_index <= REG_HTTPS_PORT;
    cfg_data <= https_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_http_port = http_val;
    cur_https_port = https_val;
    @(posedge clk);
  endtask

  task automatic test_default_ports();
    send_item(make_read(3'd0));  // empty table
    send_item(make_packet(32'h0A00_0001, 32'h0A00_0002, 16'd1000, 16'd80, 8'd17));
    send_item(make_packet(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'd80, PROTO_TCP));
    send_item(make_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd443, PROTO_TCP));
    send_item(make_packet(32'hA5A5_5A5A, 32'h0102_0304, 16'h1234, 16'd22, PROTO_TCP));
    send_item(make_packet(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'd80, PROTO_TCP));
    send_item(make_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd443, PROTO_TCP));
    // one bit off in the destination port: new flow
    send_item(make_packet(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'd81, PROTO_TCP));
    // known tuple but not TCP: table untouched
    send_item(make_packet(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'd80, 8'hFF));
    send_item(make_read(3'd0));
    send_item(make_read(3'd7));
  endtask

  task automatic test_port_extremes();
    drain_results();
    set_ports(16'h0000, 16'hFFFF);
    send_item(make_packet($urandom, $urandom, 16'($urandom), 16'h0000, PROTO_TCP));
    send_item(make_packet($urandom, $urandom, 16'($urandom), 16'hFFFF, PROTO_TCP));
    // class was fixed at creation
    send_item(make_packet(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'd80, PROTO_TCP));
    drain_results();
    set_ports(16'h1234, 16'h1234);
    // port matches both registers: HTTP wins
    send_item(make_packet($urandom, $urandom, 16'($urandom), 16'h1234, PROTO_TCP));
    send_item(make_read(3'd4));
  endtask

  task automatic test_table_full();
    logic [15:0] https_val;
    drain_results();
    https_val = 16'($urandom);
    set_ports(16'($urandom), https_val);
    send_item(make_packet(32'hC0A8_0101, 32'h08080808, 16'd5555, https_val, PROTO_TCP));
    send_item(make_packet(32'hC0A8_0102, 32'h08080808, 16'd5555, https_val, PROTO_TCP));
    send_item(make_read(3'd7));
    send_item(make_packet(32'hC0A8_0101, 32'h08080808, 16'd5555, https_val, PROTO_TCP));
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done_items;
    int unsigned kind;
    int unsigned idx;
    flow_rec_t   e;
    logic [7:0]  proto;
    done_items = 0;
    while (done_items < n_items) begin
      kind = $urandom_range(99, 0);
      idx = (flows_used == 0) ? 0 : $urandom_range(flows_used - 1, 0);
      e = flow_tab[idx];
      if (kind < 55) begin
        send_item(make_packet(e.src_addr, e.dst_addr, e.src_tcp_port, e.dst_port, PROTO_TCP));
        done_items++;
      end else if (kind < 70) begin
        send_item(make_read(IDX_W'($urandom)));
        done_items++;
      end else if (kind < 80) begin
        proto = 8'($urandom);
        if (proto == PROTO_TCP) proto = 8'd17;
        send_item(make_packet(e.src_addr, e.dst_addr, e.src_tcp_port, e.dst_port, proto));
        done_items++;
      end else begin
        // near miss on a stored tuple, or a fresh random one
        case ($urandom_range(4, 0))
          0: e.src_addr[$urandom_range(31, 0)] ^= 1'b1;
          1: e.dst_addr[$urandom_range(31, 0)] ^= 1'b1;
          2: e.src_tcp_port[$urandom_range(15, 0)] ^= 1'b1;
          3: e.dst_port[$urandom_range(15, 0)] ^= 1'b1;
          default: begin
            e.src_addr = $urandom;
            e.dst_addr = $urandom;
            e.src_tcp_port = 16'($urandom);
            e.dst_port = 16'($urandom);
          end
        endcase
        send_item(make_packet(e.src_addr, e.dst_addr, e.src_tcp_port, e.dst_port, PROTO_TCP));
        done_items++;
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (flow_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = flow_reports.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("flow_index", 32'(want.flow_index), 32'(out_data.flow_index));
        check_field("pkt_count", want.pkt_count, out_data.pkt_count);
        check_field("traffic_class", 32'(want.traffic_class), 32'(out_data.traffic_class));
        check_field("entry_src_addr", want.entry_src_addr, out_data.entry_src_addr);
        check_field("entry_dst_addr", want.entry_dst_addr, out_data.entry_dst_addr);
        check_field("entry_src_tcp_port", 32'(want.entry_src_tcp_port),
                    32'(out_data.entry_src_tcp_port));
        check_field("entry_dst_port", 32'(want.entry_dst_port), 32'(out_data.entry_dst_port));
        check_field("flows_in_use", 32'(want.flows_in_use), 32'(out_data.flows_in_use));
      end
    end
  end

  // receiver: runs of stall / no stall, with a quiet window while cycle_count[10:9] is zero
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run <= $urandom_range(24, 1);
      stall_level <= ($urandom_range(99, 0) < 40);
    end else begin
      stall_run <= stall_run - 1;
    end
    out_stall <= stall_level && (cycle_count[10:9] != 2'd0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tcp_flow_table_counter_core: FAIL");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_HTTP_PORT;
    cfg_data <= '0;
    burst_left = 4;
    flows_used = 0;
    cur_http_port = HTTP_PORT_RST;
    cur_https_port = HTTPS_PORT_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_ports();
    test_port_extremes();
    test_table_full();
    drain_results();
    set_ports(16'hFFFF, 16'h0000);
    test_random_traffic(417);
    drain_results();
    set_ports(16'($urandom), 16'($urandom));
    test_random_traffic(417);
    drain_results();
    set_ports(HTTP_PORT_RST, HTTPS_PORT_RST);
    test_random_traffic(416);
    drain_results();
    repeat (MAX_FLOWS * 3) @(posedge clk);

    if (errors == 0) begin
      $display("tb_tcp_flow_table_counter_core: PASS");
    end else begin
      $display("tb_tcp_flow_table_counter_core: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tcpft_pkg.sv
hw/rtl/tcpft_cell.sv
hw/rtl/tcp_flow_table_counter_core.sv
dv/tb_tcp_flow_table_counter_core.sv
